// File: hw/rtl/md5_pkg.sv
// Shared types, constants and round tables for the MD5 digest block.
`default_nettype none

package md5_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int POS_W       = 6;
    localparam int ROUND_W     = 6;

    localparam logic [POS_W-1:0] POS_LAST = 6'd63;
    localparam logic [POS_W-1:0] POS_LEN  = 6'd56;
    localparam logic [7:0]       PAD_BYTE = 8'h80;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [WORD_W-1:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef enum logic [1:0] {
        SEL_BYTE,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic               absorb;
        t_byte_sel          byte_sel;
        logic               len_latch;
        logic               load;
        logic               round;
        logic               fin;
        logic               emit;
        logic [ROUND_W-1:0] idx;
        logic [ROUND_W-1:0] rd_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
    } t_dp_sts;

    // message word used by a round
    function automatic logic [3:0] md5_g(input logic [ROUND_W-1:0] i);
        logic [3:0] lo;
        lo = i[3:0];
        case (i[5:4])
            2'd0:    md5_g = lo;
            2'd1:    md5_g = 4'((lo << 2) + lo + 4'd1);
            2'd2:    md5_g = 4'((lo << 1) + lo + 4'd5);
            default: md5_g = 4'((lo << 3) - lo);
        endcase
    endfunction

    function automatic logic [4:0] md5_rot(input logic [ROUND_W-1:0] i);
        case ({i[5:4], i[1:0]})
            4'd0:    md5_rot = 5'd7;
            4'd1:    md5_rot = 5'd12;
            4'd2:    md5_rot = 5'd17;
            4'd3:    md5_rot = 5'd22;
            4'd4:    md5_rot = 5'd5;
            4'd5:    md5_rot = 5'd9;
            4'd6:    md5_rot = 5'd14;
            4'd7:    md5_rot = 5'd20;
            4'd8:    md5_rot = 5'd4;
            4'd9:    md5_rot = 5'd11;
            4'd10:   md5_rot = 5'd16;
            4'd11:   md5_rot = 5'd23;
            4'd12:   md5_rot = 5'd6;
            4'd13:   md5_rot = 5'd10;
            4'd14:   md5_rot = 5'd15;
            default: md5_rot = 5'd21;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/md5_in_if.sv
// Input channel: one message byte transfer with its marks.
`default_nettype none

interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output data_byte, output byte_valid, output last,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/md5_out_if.sv
// Output channel: one digest transfer as two 64-bit halves.
`default_nettype none

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink (input valid, input digest_low, input digest_high, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/md5_message_digest_top.sv
// MD5 message digest: top level joining controller and datapath.
//
// Use: message bytes arrive on i_in, one per transfer. byte_valid marks a
// real byte; last ends the message, after any byte carried with it. An item
// with last and no byte finishes the message as it stands (empty message
// included). One digest leaves on o_out per message, as two 64-bit halves,
// byte 0 in bits 7:0 of digest_low.
// Flow: bytes are taken only while idle. Filling the 64th byte of a block
// starts compression (load, 64 single-round steps of the shared round
// unit, chain update), and intake stalls until it ends. On last, padding
// absorbs 9 to 72 bytes and brings one or two compressions, then the
// digest is registered.
// Reset clears the chaining words to the initial vector, the bit count and
// the output valid. The digest register parts the channels: new bytes are
// taken while a digest waits; only the next digest hand-off waits for the
// receiver to take the previous one.
`default_nettype none

module md5_message_digest_top
    import md5_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    md5_in_if.sink     i_in,
    md5_out_if.source  o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    md5_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_byte_valid (i_in.byte_valid),
        .i_last       (i_in.last),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    md5_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .o_sts         (sts),
        .o_digest_low  (o_out.digest_low),
        .o_digest_high (o_out.digest_high)
    );

endmodule

`default_nettype wire

// File: hw/rtl/md5_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/md5_dp.sv
// MD5 datapath: byte packing, block RAM, round registers, chain and length.
`default_nettype none

module md5_dp
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output t_dp_sts          o_sts,
    output logic      [63:0] o_digest_low,
    output logic      [63:0] o_digest_high
);

    localparam int ADDR_W = $clog2(BLOCK_WORDS);

    logic [WORD_W-1:0] r_chain [4];
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d;
    logic [63:0]       r_bit_count;
    logic [63:0]       r_len;
    logic [WORD_W-1:0] r_word;
    logic [63:0]       r_digest_low, r_digest_high;

    logic [POS_W-1:0]  pos;
    logic [7:0]        byte_in;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] sum;
    logic [63:0]       rot_wide;
    logic [WORD_W-1:0] t_new;

    assign pos = r_bit_count[8:3];

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_BYTE: byte_in = i_data_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_ZERO: byte_in = 8'h00;
            default:  byte_in = r_len[{pos[2:0], 3'b000} +: 8];
        endcase
    end

    assign ram_we    = i_cmd.absorb && (pos[1:0] == 2'b11);
    assign ram_wdata = {byte_in, r_word[WORD_W-1:8]};

    md5_ram #(
        .WIDTH(WORD_W),
        .DEPTH(BLOCK_WORDS)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pos[5:2]),
        .i_wdata (ram_wdata),
        .i_raddr (ADDR_W'(md5_g(i_cmd.rd_idx))),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (i_cmd.idx[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum      = r_a + f + ram_rdata + K_TABLE[i_cmd.idx];
        rot_wide = {sum, sum} << md5_rot(i_cmd.idx);
        t_new    = rot_wide[63:32] + r_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0]  <= IV_A;
            r_chain[1]  <= IV_B;
            r_chain[2]  <= IV_C;
            r_chain[3]  <= IV_D;
            r_bit_count <= '0;
        end else begin
            if (i_cmd.absorb) begin
                r_bit_count <= r_bit_count + 64'd8;
            end
            if (i_cmd.fin) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
            if (i_cmd.emit) begin
                r_chain[0]  <= IV_A;
                r_chain[1]  <= IV_B;
                r_chain[2]  <= IV_C;
                r_chain[3]  <= IV_D;
                r_bit_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_word <= ram_wdata;
        end
        if (i_cmd.len_latch) begin
            r_len <= r_bit_count;
        end
        if (i_cmd.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= t_new;
        end
        if (i_cmd.emit) begin
            r_digest_low  <= {r_chain[1], r_chain[0]};
            r_digest_high <= {r_chain[3], r_chain[2]};
        end
    end

    assign o_sts.pos     = pos;
    assign o_digest_low  = r_digest_low;
    assign o_digest_high = r_digest_high;

endmodule

`default_nettype wire

// File: hw/rtl/md5_ctrl.sv
// MD5 controller: byte intake, padding sequence, round sequencing, digest hand-off.
`default_nettype none

module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_byte_valid,
    input  wire logic    i_last,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADL,
        S_LOAD,
        S_ROUND,
        S_FIN,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    t_state             nxt;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;
    logic               in_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        nxt         = r_state;
        n_state     = r_state;
        n_ret       = r_ret;
        n_round     = r_round;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.absorb   = i_byte_valid;
                    o_cmd.byte_sel = SEL_BYTE;
                    nxt            = i_last ? S_PAD80 : S_IDLE;
                end
            end
            S_PAD80: begin
                o_cmd.len_latch = 1'b1;
                o_cmd.absorb    = 1'b1;
                o_cmd.byte_sel  = SEL_PAD;
                nxt             = S_PADZ;
            end
            S_PADZ: begin
                o_cmd.absorb = 1'b1;
                if (i_sts.pos == POS_LEN) begin
                    o_cmd.byte_sel = SEL_LEN;
                    nxt            = S_PADL;
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                    nxt            = S_PADZ;
                end
            end
            S_PADL: begin
                o_cmd.absorb   = 1'b1;
                o_cmd.byte_sel = SEL_LEN;
                nxt            = (i_sts.pos == POS_LAST) ? S_DONE : S_PADL;
            end
            S_LOAD: begin
                o_cmd.load   = 1'b1;
                o_cmd.rd_idx = '0;
                n_round      = '0;
                nxt          = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round  = 1'b1;
                o_cmd.idx    = r_round;
                o_cmd.rd_idx = r_round + 1'b1;
                n_round      = r_round + 1'b1;
                nxt          = (r_round == POS_LAST) ? S_FIN : S_ROUND;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                nxt       = r_ret;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    nxt         = S_IDLE;
                end
            end
            default: begin
                nxt = S_IDLE;
            end
        endcase

        // a byte landing in the last block slot triggers compression first
        if (o_cmd.absorb && (i_sts.pos == POS_LAST)) begin
            n_state = S_LOAD;
            n_ret   = nxt;
        end else begin
            n_state = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: tb/md5_message_digest_top_tb.sv
// Testbench for the MD5 digest block: random and directed messages checked against a built-in MD5.
module md5_message_digest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_HOLD_CYCLES = 1000;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_ITEMS    = 600;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_digest;

    logic i_clk;
    logic i_rst_n;

    md5_in_if  in_ch();
    md5_out_if out_ch();

    md5_message_digest_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // digest model state
    logic [31:0] chain_w [4];
    logic [7:0]  blk_bytes [64];
    logic [63:0] msg_bits;
    logic [31:0] sine_k [64];
    int          rot_amt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    t_digest expected_digests [$];
    int      fail_count;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      hold_seq;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void md5_init_chain();
        chain_w[0] = 32'h67452301;
        chain_w[1] = 32'hefcdab89;
        chain_w[2] = 32'h98badcfe;
        chain_w[3] = 32'h10325476;
        msg_bits   = 64'd0;
    endfunction

    function automatic void md5_compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int          g, s;
        for (int j = 0; j < 16; j++)
            w[j] = {blk_bytes[4*j+3], blk_bytes[4*j+2], blk_bytes[4*j+1], blk_bytes[4*j]};
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int j = 0; j < 64; j++) begin
            case (j / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = j;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * j + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * j + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * j) % 16;
                end
            endcase
            t = a + f + w[g] + sine_k[j];
            s = rot_amt[(j / 16) * 4 + (j % 4)];
            t = ((t << s) | (t >> (32 - s))) + b;
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_w[0] += a;
        chain_w[1] += b;
        chain_w[2] += c;
        chain_w[3] += d;
    endfunction

    function automatic void md5_absorb(input logic [7:0] v);
        logic [5:0] pos;
        pos = msg_bits[8:3];
        blk_bytes[pos] = v;
        msg_bits += 64'd8;
        if (pos == 6'd63)
            md5_compress_block();
    endfunction

    function automatic void predict_digest(input logic [7:0] d, input logic bv, input logic lst);
        logic [63:0] len;
        t_digest     want;
        if (bv)
            md5_absorb(d);
        if (lst) begin
            len = msg_bits;
            md5_absorb(8'h80);
            while (msg_bits[8:3] != 6'd56)
                md5_absorb(8'h00);
            for (int k = 0; k < 8; k++)
                md5_absorb(len[8*k +: 8]);
            want.lo = {chain_w[1], chain_w[0]};
            want.hi = {chain_w[3], chain_w[2]};
            expected_digests.push_back(want);
            md5_init_chain();
        end
    endfunction

    // one input transfer; returns just after the accepting edge
    task automatic send_item(input logic [7:0] d, input logic bv, input logic lst);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= d;
        in_ch.byte_valid <= bv;
        in_ch.last       <= lst;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_digest(d, bv, lst);
    endtask

    task automatic drain_digests();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_digests.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_message();
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        drain_digests();
    endtask

    task automatic test_single_bytes();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        drain_digests();
    endtask

    task automatic test_ignored_items();
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        drain_digests();
    endtask

    task automatic test_last_alone();
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        drain_digests();
    endtask

    // receiver stalls for a long stretch while short messages keep coming
    task automatic test_output_hold_off();
        int len;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        hold_seq++;
        for (int m = 0; m < 6; m++) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
                send_item(8'($urandom_range(255)), 1'b1, k == len - 1);
        end
        drain_digests();
    endtask

    task automatic test_random_messages(input int n_items, input int tx_pct, input int rx_pct);
        int   sent;
        int   len;
        int   r;
        logic tail_byte;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 35)
                len = $urandom_range(0, 20);
            else if (r < 65)
                len = $urandom_range(50, 70);
            else if (r < 82)
                len = $urandom_range(110, 130);
            else if (r < 96)
                len = $urandom_range(0, 64);
            else
                len = $urandom_range(180, 260);
            tail_byte = (len > 0) && ($urandom_range(1) == 1);
            for (int k = 0; k < len; k++) begin
                while ($urandom_range(99) < 4) begin
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                    sent++;
                end
                send_item(8'($urandom_range(255)), 1'b1, tail_byte && (k == len - 1));
            end
            if (!tail_byte)
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            sent += len + (tail_byte ? 0 : 1);
        end
        drain_digests();
    endtask

    // receiver: ready at the falling edge, long hold-off on request
    initial begin : digest_receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : digest_check
        t_digest want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_digests.size() == 0) begin
                $display("%0t: unexpected digest transfer %h %h", $time,
                         out_ch.digest_high, out_ch.digest_low);
                fail_count++;
            end else begin
                want = expected_digests.pop_front();
                if (out_ch.digest_low !== want.lo) begin
                    $display("%0t: digest_low expected %h, got %h", $time, want.lo,
                             out_ch.digest_low);
                    fail_count++;
                end
                if (out_ch.digest_high !== want.hi) begin
                    $display("%0t: digest_high expected %h, got %h", $time, want.hi,
                             out_ch.digest_high);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        real v;
        for (int j = 0; j < 64; j++) begin
            v = $sin(j + 1);
            if (v < 0.0)
                v = -v;
            sine_k[j] = 32'(longint'($floor(v * 4294967296.0)));
        end
        md5_init_chain();
        fail_count       = 0;
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        hold_seq         = 0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.byte_valid = 1'b0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_single_bytes();
        test_ignored_items();
        test_last_alone();
        test_output_hold_off();
        test_random_messages(PHASE_ITEMS, 22, 66);
        test_random_messages(PHASE_ITEMS, 66, 22);
        test_random_messages(PHASE_ITEMS, 0, 0);

        drain_digests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
